### sv/assert_macros.svh
// Assertion helpers used by gga_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ck, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, ck, rst_n, ante, cons)
`endif
`endif

### sv/gga_pkg.sv
// -----------------------------------------------------------------------------
// gga_pkg
// Types and constants of the Green-Gauss gradient accumulator.
// -----------------------------------------------------------------------------
`default_nettype none
package gga_pkg;
	localparam int MAX_CELLS   = 1024;
	localparam int NUM_VARS    = 4;
	localparam int CELL_W      = $clog2(MAX_CELLS);
	localparam int VAR_W       = $clog2(NUM_VARS);
	localparam int ENTRIES     = MAX_CELLS * NUM_VARS;
	localparam int ENT_W       = CELL_W + VAR_W;
	localparam int ACC_W       = 48;
	localparam int RC_W        = 11;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int DIV_W       = 64;
	localparam int DIV_CNT_W   = $clog2(DIV_W);

	typedef enum logic [1:0] {
		FUNC_LOAD = 2'd0,
		FUNC_EDGE = 2'd1,
		FUNC_READ = 2'd2,
		FUNC_NOP  = 2'd3
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [9:0]         cell_a;
		logic [9:0]         cell_b;
		logic [1:0]         var_index;
		logic signed [31:0] cell_value;
		logic [31:0]        cell_area;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic [31:0]        edge_len;
	} item_t;

	typedef struct packed {
		logic signed [31:0] grad_x;
		logic signed [31:0] grad_y;
		logic               saturated;
	} grad_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;
endpackage
`default_nettype wire

### sv/gga_front.sv
// -----------------------------------------------------------------------------
// gga_front
// Accepts items, drops those with no effect and queues the rest.
// -----------------------------------------------------------------------------
`default_nettype none
module gga_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire gga_pkg::item_t     item,
	input  wire gga_pkg::back_stat_t stat,
	output logic                    q_valid,
	output gga_pkg::item_t          q_item,
	input  wire logic               q_pop
);
	import gga_pkg::*;

	item_t              fifo_mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QPTR_W:0]    cnt_q;
	logic               keep;
	logic               push;

	assign item_ready = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH)) && !stat.clearing;
	// drop no-ops and edges from a cell to itself
	assign keep = (item.func == FUNC_LOAD) || (item.func == FUNC_READ) ||
		((item.func == FUNC_EDGE) && (item.cell_a != item.cell_b));
	assign push = item_valid && item_ready && keep;
	assign q_valid = (cnt_q != '0);
	assign q_item = fifo_mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10: begin
					cnt_q <= cnt_q + 1'b1;
				end
				2'b01: begin
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

### sv/gga_div.sv
// -----------------------------------------------------------------------------
// gga_div
// Restoring unsigned divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
`default_nettype none
module gga_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [gga_pkg::DIV_W-1:0] dividend,
	input  wire logic [31:0]               divisor,
	output logic                           done,
	output logic [gga_pkg::DIV_W-1:0]      quotient
);
	import gga_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [31:0]          rem_q;
	logic [31:0]          dvs_q;
	logic [DIV_W-1:0]     dq_q;
	logic [32:0]          rem_sh;
	logic [32:0]          diff;
	logic                 ge;

	assign rem_sh = {rem_q, dq_q[DIV_W-1]};
	assign diff = rem_sh - {1'b0, dvs_q};
	assign ge = (rem_sh >= {1'b0, dvs_q});
	assign done = done_q;
	assign quotient = dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : rem_sh[31:0];
			dq_q  <= {dq_q[DIV_W-2:0], ge};
		end
	end
endmodule
`default_nettype wire

### sv/gga_back.sv
// -----------------------------------------------------------------------------
// gga_back
// Executes queued items against the cell memories and drives results.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module gga_back (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     q_valid,
	input  wire gga_pkg::item_t           q_item,
	output logic                          q_pop,
	output gga_pkg::back_stat_t           stat,
	input  wire logic [gga_pkg::RC_W-1:0] real_cells,
	output logic                          grad_valid,
	input  wire logic                     grad_ready,
	output gga_pkg::grad_t                grad
);
	import gga_pkg::*;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_LOAD, S_ERD, S_ESUM, S_EMUL1, S_EFRND, S_EMUL2,
		S_ETRND, S_EWRA, S_EWRB, S_RRD, S_RCHK, S_RDIV, S_OUT
	} state_t;

	logic [31:0]      value_mem [ENTRIES];
	logic [31:0]      area_mem [MAX_CELLS];
	logic [ACC_W-1:0] sumx_mem [ENTRIES];
	logic [ACC_W-1:0] sumy_mem [ENTRIES];

	state_t           state_q;
	logic [ENT_W-1:0] clr_q;
	logic [VAR_W-1:0] k_q;
	logic             grad_valid_q;
	grad_t            grad_q;

	item_t            cmd_q;
	logic [31:0]      va_q, vb_q, area_rd_q;
	logic [ACC_W-1:0] sxa_q, sxb_q, sya_q, syb_q;
	logic [32:0]      s_q;
	logic             sneg_q;
	logic [64:0]      p1_q;
	logic [47:0]      f_q;
	logic [63:0]      pxm_q, pym_q;
	logic [48:0]      tx_q, ty_q;
	logic             negx_q, negy_q;
	grad_t            res_q;

	logic [VAR_W-1:0] sel_var;
	logic [ENT_W-1:0] ea, eb;
	logic             rd_en;
	logic             sum_we;
	logic [ENT_W-1:0] sum_wa;
	logic [ACC_W-1:0] wx, wy;
	logic [32:0]      sm;
	logic [64:0]      p1_rnd;
	logic [15:0]      nxm, nym;
	logic [63:0]      px_rnd, py_rnd;
	logic             is_real;
	logic             div_go;
	logic [ACC_W-1:0] mx, my;
	logic             dx_done, dy_done;
	logic [63:0]      qx, qy;
	logic [32:0]      gx, gy;
	logic             out_fire;

	function automatic logic [ACC_W-1:0] acc_sat(input logic [ACC_W+1:0] v);
		logic [ACC_W-1:0] r;
		if (v[ACC_W+1:ACC_W-1] == '0 || v[ACC_W+1:ACC_W-1] == '1) begin
			r = v[ACC_W-1:0];
		end else if (v[ACC_W+1]) begin
			r = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(ACC_W-1){1'b1}}};
		end
		return r;
	endfunction

	// clip a quotient magnitude to 32 signed bits; top bit flags the clip
	function automatic logic [32:0] grad_fix(input logic neg, input logic [63:0] q);
		logic [32:0] r;
		if (neg) begin
			if (q > 64'h8000_0000) begin
				r = {1'b1, 32'h8000_0000};
			end else begin
				r = {1'b0, 32'(64'd0 - q)};
			end
		end else if (q > 64'h7FFF_FFFF) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else begin
			r = {1'b0, q[31:0]};
		end
		return r;
	endfunction

	assign stat.clearing = (state_q == S_CLR);
	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign grad_valid = grad_valid_q;
	assign grad = grad_q;
	assign out_fire = (state_q == S_OUT) && (!grad_valid_q || grad_ready);

	assign sel_var = (cmd_q.func == FUNC_EDGE) ? k_q : cmd_q.var_index[VAR_W-1:0];
	assign ea = {cmd_q.cell_a[CELL_W-1:0], sel_var};
	assign eb = {cmd_q.cell_b[CELL_W-1:0], k_q};
	assign rd_en = (state_q == S_ERD) || (state_q == S_RRD);

	assign sm = s_q[32] ? (33'd0 - s_q) : s_q;
	assign p1_rnd = p1_q + 65'd65536;
	assign nxm = cmd_q.normal_x[15] ? (16'd0 - cmd_q.normal_x) : cmd_q.normal_x;
	assign nym = cmd_q.normal_y[15] ? (16'd0 - cmd_q.normal_y) : cmd_q.normal_y;
	assign px_rnd = pxm_q + 64'd16384;
	assign py_rnd = pym_q + 64'd16384;

	assign is_real = ({1'b0, cmd_q.cell_a} < real_cells);
	assign div_go = (state_q == S_RCHK) && is_real && (area_rd_q != '0);
	assign mx = sxa_q[ACC_W-1] ? (ACC_W'(0) - sxa_q) : sxa_q;
	assign my = sya_q[ACC_W-1] ? (ACC_W'(0) - sya_q) : sya_q;
	assign gx = grad_fix(negx_q, qx);
	assign gy = grad_fix(negy_q, qy);

	always_comb begin
		sum_we = 1'b0;
		sum_wa = ea;
		wx = '0;
		wy = '0;
		case (state_q)
			S_CLR: begin
				sum_we = 1'b1;
				sum_wa = clr_q;
			end
			S_LOAD: begin
				sum_we = 1'b1;
			end
			S_EWRA: begin
				sum_we = 1'b1;
				wx = acc_sat({{2{sxa_q[ACC_W-1]}}, sxa_q} + {tx_q[48], tx_q});
				wy = acc_sat({{2{sya_q[ACC_W-1]}}, sya_q} + {ty_q[48], ty_q});
			end
			S_EWRB: begin
				sum_we = 1'b1;
				sum_wa = eb;
				wx = acc_sat({{2{sxb_q[ACC_W-1]}}, sxb_q} - {tx_q[48], tx_q});
				wy = acc_sat({{2{syb_q[ACC_W-1]}}, syb_q} - {ty_q[48], ty_q});
			end
			default: begin
				sum_we = 1'b0;
			end
		endcase
	end

	gga_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend ({mx, 16'd0}),
		.divisor  (area_rd_q),
		.done     (dx_done),
		.quotient (qx)
	);

	gga_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend ({my, 16'd0}),
		.divisor  (area_rd_q),
		.done     (dy_done),
		.quotient (qy)
	);

	// memories
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			value_mem[ea] <= cmd_q.cell_value;
			area_mem[cmd_q.cell_a[CELL_W-1:0]] <= cmd_q.cell_area;
		end
		if (sum_we) begin
			sumx_mem[sum_wa] <= wx;
			sumy_mem[sum_wa] <= wy;
		end
		if (rd_en) begin
			va_q      <= value_mem[ea];
			vb_q      <= value_mem[eb];
			sxa_q     <= sumx_mem[ea];
			sxb_q     <= sumx_mem[eb];
			sya_q     <= sumy_mem[ea];
			syb_q     <= sumy_mem[eb];
			area_rd_q <= area_mem[cmd_q.cell_a[CELL_W-1:0]];
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_item;
		end
		case (state_q)
			S_ESUM: begin
				s_q <= {va_q[31], va_q} + {vb_q[31], vb_q};
			end
			S_EMUL1: begin
				p1_q   <= {32'd0, sm} * {33'd0, cmd_q.edge_len};
				sneg_q <= s_q[32];
			end
			S_EFRND: begin
				f_q <= p1_rnd[64:17];
			end
			S_EMUL2: begin
				pxm_q <= {16'd0, f_q} * {48'd0, nxm};
				pym_q <= {16'd0, f_q} * {48'd0, nym};
			end
			S_ETRND: begin
				tx_q <= (sneg_q ^ cmd_q.normal_x[15]) ?
					(49'd0 - {1'b0, px_rnd[62:15]}) : {1'b0, px_rnd[62:15]};
				ty_q <= (sneg_q ^ cmd_q.normal_y[15]) ?
					(49'd0 - {1'b0, py_rnd[62:15]}) : {1'b0, py_rnd[62:15]};
			end
			S_RCHK: begin
				negx_q <= sxa_q[ACC_W-1];
				negy_q <= sya_q[ACC_W-1];
				res_q.grad_x    <= '0;
				res_q.grad_y    <= '0;
				res_q.saturated <= is_real && (area_rd_q == '0);
			end
			S_RDIV: begin
				if (dx_done) begin
					res_q.grad_x    <= gx[31:0];
					res_q.grad_y    <= gy[31:0];
					res_q.saturated <= gx[32] | gy[32];
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			k_q          <= '0;
			grad_valid_q <= 1'b0;
			grad_q       <= '0;
		end else begin
			if (out_fire) begin
				grad_valid_q <= 1'b1;
			end else if (grad_valid_q && grad_ready) begin
				grad_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ENT_W'(ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					k_q <= '0;
					if (q_valid) begin
						case (q_item.func)
							FUNC_LOAD: state_q <= S_LOAD;
							FUNC_EDGE: state_q <= S_ERD;
							FUNC_READ: state_q <= S_RRD;
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_LOAD:  state_q <= S_IDLE;
				S_ERD:   state_q <= S_ESUM;
				S_ESUM:  state_q <= S_EMUL1;
				S_EMUL1: state_q <= S_EFRND;
				S_EFRND: state_q <= S_EMUL2;
				S_EMUL2: state_q <= S_ETRND;
				S_ETRND: state_q <= S_EWRA;
				S_EWRA:  state_q <= S_EWRB;
				S_EWRB: begin
					// advance to the next variable or finish the edge
					if (k_q == VAR_W'(NUM_VARS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_ERD;
					end
				end
				S_RRD: state_q <= S_RCHK;
				S_RCHK: begin
					state_q <= div_go ? S_RDIV : S_OUT;
				end
				S_RDIV: begin
					if (dx_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the output register is free
					if (out_fire) begin
						grad_q  <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMP(a_div_lockstep, clk, arst_n, 1'b1, dx_done == dy_done)
	`ASSERT_IMP(a_out_from_seq, clk, arst_n, $rose(grad_valid_q), $past(state_q) == S_OUT)
	`ASSERT_IMP(a_edge_distinct, clk, arst_n, state_q == S_EWRA || state_q == S_EWRB, cmd_q.cell_a != cmd_q.cell_b)
	`ASSERT_NEXT(a_clear_done, clk, arst_n, state_q == S_CLR && clr_q == ENT_W'(ENTRIES - 1), state_q == S_IDLE)
endmodule
`default_nettype wire

### sv/green_gauss_gradient_accumulator_core.sv
// -----------------------------------------------------------------------------
// green_gauss_gradient_accumulator_core
// Fixed-point Green-Gauss cell gradient accumulator.
// -----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item): load, edge, read or no-op items.
//   grad channel (grad_valid/grad_ready/grad): one result per read item.
//   cfg_wen/cfg_wdata write real_cells; write only while the block is idle.
// Items pass a four-entry queue into a sequencer that owns the cell memories.
// Back-end work per item: a load writes the cell memories once; an edge runs a
//   read-modify-write of the sum memories, one variable at a time through one
//   write port; a read of a real cell with nonzero area waits on the
//   bit-serial 64-step divider. No-ops and same-cell edges are dropped at entry.
// A waiting result sits in the output register; the queue keeps accepting until
//   full, then item_ready drops.
// After reset a clearing pass zeroes all 4096 entries of the sum memories;
//   item_ready stays low until it ends. real_cells resets to zero.
`default_nettype none
module green_gauss_gradient_accumulator_core (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     item_valid,
	output logic                          item_ready,
	input  wire gga_pkg::item_t           item,
	output logic                          grad_valid,
	input  wire logic                     grad_ready,
	output gga_pkg::grad_t                grad,
	input  wire logic                     cfg_wen,
	input  wire logic [gga_pkg::RC_W-1:0] cfg_wdata
);
	import gga_pkg::*;

	logic [RC_W-1:0] real_cells_q;
	logic            q_valid;
	item_t           q_item;
	logic            q_pop;
	back_stat_t      stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_cells_q <= '0;
		end else if (cfg_wen) begin
			real_cells_q <= cfg_wdata;
		end
	end

	gga_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.stat       (stat),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	gga_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.stat       (stat),
		.real_cells (real_cells_q),
		.grad_valid (grad_valid),
		.grad_ready (grad_ready),
		.grad       (grad)
	);
endmodule
`default_nettype wire

### bench/tb_top.sv
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Green-Gauss gradient accumulator core. Drives
// load, edge, read and no-op items with random gaps on both channels, predicts
// each read result from a local fixed-point model, and checks results in order.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import gga_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int ITEM_W = $bits(item_t);
	localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_MIN = -64'sh0000_8000_0000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic grad_valid;
	logic grad_ready = 1'b0;
	grad_t grad;
	logic cfg_wen = 1'b0;
	logic [RC_W-1:0] cfg_wdata = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off = 1'b0;
	int errors = 0;
	int quiet_cycles = 0;

	// Gradient predictor with its own copy of the cell memories.
	class gradient_board;
		logic [10:0] real_cells;
		logic signed [31:0] cell_val[ENTRIES];
		logic [31:0] cell_area[MAX_CELLS];
		longint sum_x[ENTRIES];
		longint sum_y[ENTRIES];
		grad_t pending[$];

		function new();
			real_cells = '0;
			foreach (sum_x[i]) begin
				sum_x[i] = 0;
				sum_y[i] = 0;
				cell_val[i] = '0;
			end
			foreach (cell_area[i]) cell_area[i] = '0;
		endfunction

		function longint clip_sum(longint v);
			if (v > SUM_MAX) return SUM_MAX;
			if (v < SUM_MIN) return SUM_MIN;
			return v;
		endfunction

		function longint face_term(longint s, logic [31:0] len, logic signed [15:0] n);
			logic [63:0] sm, nm, f, p;
			sm = (s < 0) ? -s : s;
			nm = (n < 0) ? -longint'(n) : longint'(n);
			f = (sm * {32'd0, len} + 64'd65536) >> 17;
			p = (f * nm + 64'd16384) >> 15;
			return ((s < 0) != (n < 0)) ? -longint'(p) : longint'(p);
		endfunction

		function logic [31:0] scale_sum(longint acc, logic [31:0] area, inout bit sat);
			logic [63:0] m, q;
			m = (acc < 0) ? -acc : acc;
			q = (m << 16) / {32'd0, area};
			if (acc < 0) begin
				if (q > 64'h8000_0000) begin
					sat = 1'b1;
					return 32'h8000_0000;
				end
				return 32'(-q);
			end
			if (q > 64'h7FFF_FFFF) begin
				sat = 1'b1;
				return 32'h7FFF_FFFF;
			end
			return q[31:0];
		endfunction

		function void note_item(item_t it);
			int ea, eb;
			longint s, tx, ty;
			grad_t g;
			bit sat;
			case (it.func)
				FUNC_LOAD: begin
					ea = it.cell_a * NUM_VARS + it.var_index;
					cell_val[ea] = it.cell_value;
					cell_area[it.cell_a] = it.cell_area;
					sum_x[ea] = 0;
					sum_y[ea] = 0;
				end
				FUNC_EDGE: begin
					if (it.cell_a != it.cell_b) begin
						for (int k = 0; k < NUM_VARS; k++) begin
							ea = it.cell_a * NUM_VARS + k;
							eb = it.cell_b * NUM_VARS + k;
							s = longint'(cell_val[ea]) + longint'(cell_val[eb]);
							tx = face_term(s, it.edge_len, it.normal_x);
							ty = face_term(s, it.edge_len, it.normal_y);
							sum_x[ea] = clip_sum(sum_x[ea] + tx);
							sum_y[ea] = clip_sum(sum_y[ea] + ty);
							sum_x[eb] = clip_sum(sum_x[eb] - tx);
							sum_y[eb] = clip_sum(sum_y[eb] - ty);
						end
					end
				end
				FUNC_READ: begin
					g = '0;
					sat = 1'b0;
					if (it.cell_a < real_cells) begin
						ea = it.cell_a * NUM_VARS + it.var_index;
						if (cell_area[it.cell_a] == 0) sat = 1'b1;
						else begin
							g.grad_x = scale_sum(sum_x[ea], cell_area[it.cell_a], sat);
							g.grad_y = scale_sum(sum_y[ea], cell_area[it.cell_a], sat);
						end
					end
					g.saturated = sat;
					pending.push_back(g);
				end
				default: ;
			endcase
		endfunction

		function int check_result(grad_t got);
			grad_t exp_g;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				return 1;
			end
			exp_g = pending.pop_front();
			if (got.grad_x !== exp_g.grad_x || got.grad_y !== exp_g.grad_y ||
					got.saturated !== exp_g.saturated) begin
				$display("%0t: mismatch expected x=%h y=%h sat=%b actual x=%h y=%h sat=%b",
					$time, exp_g.grad_x, exp_g.grad_y, exp_g.saturated,
					got.grad_x, got.grad_y, got.saturated);
				return 1;
			end
			return 0;
		endfunction
	endclass

	gradient_board board = new();

	// Every written (cell, var) has its value loaded; reads touch those, or cells beyond real_cells.
	bit loaded[ENTRIES];
	bit area_set[MAX_CELLS];
	int loaded_cells[$];

	green_gauss_gradient_accumulator_core dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.grad_valid(grad_valid), .grad_ready(grad_ready), .grad(grad),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) board.note_item(item);
			if (grad_valid && grad_ready) errors += board.check_result(grad);
			if ((item_valid && item_ready) || (grad_valid && grad_ready))
				quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when asked.
	always @(posedge clk) begin
		if (hold_off) grad_ready <= 1'b0;
		else grad_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Valid stays up after acceptance so the next item can follow at once;
	// drop it when idling or before waiting on anything else.
	task automatic send_item(item_t it);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	task automatic write_real_cells(int n);
		item_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= RC_W'(n);
		@(posedge clk);
		cfg_wen <= 1'b0;
		board.real_cells = RC_W'(n);
	endtask

	function automatic item_t rand_item();
		return item_t'(ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
	endfunction

	function automatic item_t load_item(int c, int v, logic [31:0] val, logic [31:0] area);
		item_t it;
		it = rand_item();
		it.func = FUNC_LOAD;
		it.cell_a = 10'(c);
		it.var_index = 2'(v);
		it.cell_value = val;
		it.cell_area = area;
		return it;
	endfunction

	function automatic item_t edge_item(int a, int b, logic [15:0] nx, logic [15:0] ny,
			logic [31:0] len);
		item_t it;
		it = rand_item();
		it.func = FUNC_EDGE;
		it.cell_a = 10'(a);
		it.cell_b = 10'(b);
		it.normal_x = nx;
		it.normal_y = ny;
		it.edge_len = len;
		return it;
	endfunction

	function automatic item_t read_item(int c, int v);
		item_t it;
		it = rand_item();
		it.func = FUNC_READ;
		it.cell_a = 10'(c);
		it.var_index = 2'(v);
		return it;
	endfunction

	// Load all variables of a cell so edges and reads never see unwritten data.
	task automatic load_cell(int c, logic [31:0] area, bit wide);
		logic [31:0] val;
		for (int v = 0; v < NUM_VARS; v++) begin
			val = wide ? $urandom : 32'($signed($urandom_range(2000000)) - 1000000);
			send_item(load_item(c, v, val, area));
			loaded[c * NUM_VARS + v] = 1'b1;
		end
		if (!area_set[c]) loaded_cells.push_back(c);
		area_set[c] = 1'b1;
	endtask

	function automatic int pick_cell();
		return loaded_cells[$urandom_range(loaded_cells.size() - 1)];
	endfunction

	function automatic logic [31:0] rand_area();
		case ($urandom_range(3))
			0: return $urandom_range(32'h0001_0000, 32'h0000_4000);
			1: return $urandom;
			default: return $urandom_range(32'h0040_0000, 32'h0001_0000);
		endcase
	endfunction

	task automatic random_phase(int count);
		item_t it;
		int a, b;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(19))
				0, 1: load_cell($urandom_range(MAX_CELLS - 1), rand_area(),
					1'($urandom_range(1)));
				2, 3, 4, 5, 6, 7, 8, 9: begin
					a = pick_cell();
					b = ($urandom_range(15) == 0) ? a : pick_cell();
					send_item(edge_item(a, b, 16'($urandom), 16'($urandom),
						$urandom_range(1) ? $urandom : $urandom_range(32'h0004_0000)));
				end
				10, 11, 12, 13, 14, 15, 16: begin
					it = read_item(pick_cell(), $urandom_range(NUM_VARS - 1));
					send_item(it);
				end
				17: begin
					// reads of boundary or never-loaded cells answer zero only if beyond real_cells
					a = $urandom_range(MAX_CELLS - 1);
					if (area_set[a] || a >= board.real_cells)
						send_item(read_item(a, $urandom_range(NUM_VARS - 1)));
				end
				18: begin
					it = rand_item();
					it.func = FUNC_NOP;
					send_item(it);
				end
				default: begin
					a = pick_cell();
					send_item(load_item(a, $urandom_range(NUM_VARS - 1), $urandom,
						$urandom_range(1) ? rand_area() : 32'd0));
				end
			endcase
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, load, edge and read items, special cases.
		write_real_cells(1024);
		load_cell(0, 32'h0001_0000, 1'b0);
		load_cell(1, 32'h0001_0000, 1'b0);
		load_cell(1023, 32'hFFFF_FFFF, 1'b1);
		send_item(load_item(2, 0, 32'h7FFF_FFFF, 32'h0000_0001));
		send_item(load_item(3, 0, 32'h8000_0000, 32'h0000_0001));
		for (int v = 1; v < NUM_VARS; v++) begin
			send_item(load_item(2, v, 32'h7FFF_FFFF, 32'h0000_0001));
			send_item(load_item(3, v, 32'h8000_0000, 32'h0000_0001));
		end
		loaded_cells.push_back(2);
		loaded_cells.push_back(3);
		area_set[2] = 1'b1;
		area_set[3] = 1'b1;
		send_item(edge_item(0, 1, 16'h7FFF, 16'h8000, 32'h0001_0000));
		send_item(edge_item(2, 2, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF));
		send_item(edge_item(2, 3, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF));
		send_item(edge_item(2, 1023, 16'h8000, 16'h8000, 32'hFFFF_FFFF));
		send_item(edge_item(1, 0, 16'h0000, 16'hFFFF, 32'h0000_0000));
		send_item(read_item(0, 0));
		send_item(read_item(2, 3));
		send_item(read_item(3, 0));
		send_item(read_item(1023, 3));
		send_item(load_item(1, 2, 32'h0000_0000, 32'h0000_0000));
		send_item(read_item(1, 2));
		write_real_cells(0);
		send_item(read_item(0, 0));
		send_item(read_item(500, 1));

		for (int c = 4; c < 40; c++) load_cell(c, rand_area(), 1'($urandom_range(1)));

		// Long receiver hold-off while items keep coming: fills the queue.
		write_real_cells(1023);
		hold_off = 1'b1;
		fork
			begin
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end
			random_phase(40);
		join
		write_real_cells(1000);

		send_idle_pct = 35;
		recv_idle_pct = 68;
		random_phase(250);
		write_real_cells($urandom_range(1, 600));
		send_idle_pct = 68;
		recv_idle_pct = 35;
		random_phase(250);
		write_real_cells(1024);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(250);

		item_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

### files.f
+incdir+sv
sv/gga_pkg.sv
sv/gga_front.sv
sv/gga_div.sv
sv/gga_back.sv
sv/green_gauss_gradient_accumulator_core.sv
bench/tb_top.sv
